[design/lnsr_pkg.sv]
// Shared types, codes and reset constants of the I/Q leakage null search.
`timescale 1ns / 1ps

package lnsr_pkg;

    // Port widths
    localparam int S_TDATA_W  = 16;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 40;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 12;
    localparam int LEVEL_W    = 12;
    localparam int OUT_CODE_W = 12;

    // Word kinds carried on s_tuser
    typedef enum logic [1:0] {
        ACT_FAST   = 2'd0,
        ACT_FULL   = 2'd1,
        ACT_SAMPLE = 2'd2,
        ACT_NOP    = 2'd3
    } action_t;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_SCAN_LOW      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SCAN_HIGH     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_COARSE_STEP   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_FINE_STEP     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_FINE_RANGE    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_COARSE_MARGIN = 3'd5;

    // Register reset values
    localparam logic [11:0] SCAN_LOW_RST      = 12'd124;
    localparam logic [11:0] SCAN_HIGH_RST     = 12'd1860;
    localparam logic [11:0] COARSE_STEP_RST   = 12'd62;
    localparam logic [11:0] FINE_STEP_RST     = 12'd24;
    localparam logic [10:0] FINE_RANGE_RST    = 11'd124;
    localparam logic [11:0] COARSE_MARGIN_RST = 12'd0;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 12'd4095;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_QSWEEP  = 3'd1,
        PH_ISWEEP  = 3'd2,
        PH_FINE    = 3'd3,
        PH_GRID    = 3'd4,
        PH_CONFIRM = 3'd5,
        PH_DONE    = 3'd6
    } phase_t;

    typedef struct packed {
        logic [11:0] scan_low;
        logic [11:0] scan_high;
        logic [11:0] coarse_step;
        logic [11:0] fine_step;
        logic [10:0] fine_range;
        logic [11:0] coarse_margin;
    } cfg_t;

    // Seed table write strobes: per-seed store, and a write to seed 0
    typedef struct packed {
        logic st_en;
        logic w0_en;
        logic w0_lvl_en;
    } seed_wr_t;

    // Result word, first field in the highest bits
    typedef struct packed {
        logic [1:0]            best_seed;
        logic [LEVEL_W-1:0]    best_level;
        logic                  done_res;
        logic                  sample_wanted;
        logic [OUT_CODE_W-1:0] dac_q;
        logic [OUT_CODE_W-1:0] dac_i;
    } result_t;

    function automatic logic [11:0] seed_i_init(input int k);
        logic [11:0] v;
        case (k)
            0:       v = 12'd1448;
            1:       v = 12'd1426;
            2:       v = 12'd1178;
            3:       v = 12'd1880;
            default: v = 12'd0;
        endcase
        return v;
    endfunction

    function automatic logic [11:0] seed_q_init(input int k);
        logic [11:0] v;
        case (k)
            0:       v = 12'd1302;
            1:       v = 12'd1240;
            2:       v = 12'd1116;
            3:       v = 12'd1054;
            default: v = 12'd0;
        endcase
        return v;
    endfunction

endpackage

[design/lnsr_seed_tab.sv]
// Seed tables (codes and levels) with the best-seed selection tree.
`timescale 1ns / 1ps

module lnsr_seed_tab #(
    parameter int NUM_SEEDS = 4,
    parameter int DAC_BITS  = 12
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lnsr_pkg::seed_wr_t            wr,
    input  logic [SIW-1:0]                st_idx,
    input  logic [BW-1:0]                 st_i,
    input  logic [BW-1:0]                 st_q,
    input  logic [lnsr_pkg::LEVEL_W-1:0]  st_l,
    input  logic [BW-1:0]                 w0_i,
    input  logic [BW-1:0]                 w0_q,
    input  logic [lnsr_pkg::LEVEL_W-1:0]  w0_l,
    input  logic [SIW-1:0]                rd_addr,
    output logic [BW-1:0]                 rd_i,
    output logic [BW-1:0]                 rd_q,
    output logic [lnsr_pkg::LEVEL_W-1:0]  rd_l,
    output logic [SIW-1:0]                pk_idx,
    output logic [BW-1:0]                 pk_i,
    output logic [BW-1:0]                 pk_q,
    output logic [lnsr_pkg::LEVEL_W-1:0]  pk_l
);
    localparam int BW  = (DAC_BITS > 13) ? DAC_BITS : 13;
    localparam int SIW = (NUM_SEEDS > 1) ? $clog2(NUM_SEEDS) : 1;
    localparam int LG  = $clog2(NUM_SEEDS);
    localparam int P   = 1 << LG;
    localparam int NN  = 2 * P - 1;

    import lnsr_pkg::*;

    logic [BW-1:0]      tab_i_reg [NUM_SEEDS];
    logic [BW-1:0]      tab_q_reg [NUM_SEEDS];
    logic [LEVEL_W-1:0] tab_l_reg [NUM_SEEDS];

    // selection tree nodes, heap order, leaves at P-1 ..
    logic               nd_v [NN];
    logic [LEVEL_W-1:0] nd_l [NN];
    logic [SIW-1:0]     nd_x [NN];
    logic [BW-1:0]      nd_i [NN];
    logic [BW-1:0]      nd_q [NN];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_SEEDS; k++) begin
                tab_i_reg[k] <= BW'(seed_i_init(k));
                tab_q_reg[k] <= BW'(seed_q_init(k));
                tab_l_reg[k] <= LEVEL_MAX;
            end
        end else begin
            if (wr.st_en) begin
                tab_i_reg[st_idx] <= st_i;
                tab_q_reg[st_idx] <= st_q;
                tab_l_reg[st_idx] <= st_l;
            end
            if (wr.w0_en) begin
                tab_i_reg[0] <= w0_i;
                tab_q_reg[0] <= w0_q;
                if (wr.w0_lvl_en) begin
                    tab_l_reg[0] <= w0_l;
                end
            end
        end
    end

    assign rd_i = tab_i_reg[rd_addr];
    assign rd_q = tab_q_reg[rd_addr];
    assign rd_l = tab_l_reg[rd_addr];

    // Leaves see a store of this cycle so the pick at the end of a run includes it
    for (genvar j = 0; j < P; j++) begin : g_leaf
        if (j < NUM_SEEDS) begin : g_used
            logic hit;
            assign hit = wr.st_en && (st_idx == SIW'(j));
            assign nd_v[P-1+j] = 1'b1;
            assign nd_l[P-1+j] = hit ? st_l : tab_l_reg[j];
            assign nd_i[P-1+j] = hit ? st_i : tab_i_reg[j];
            assign nd_q[P-1+j] = hit ? st_q : tab_q_reg[j];
            assign nd_x[P-1+j] = SIW'(j);
        end else begin : g_pad
            assign nd_v[P-1+j] = 1'b0;
            assign nd_l[P-1+j] = LEVEL_MAX;
            assign nd_i[P-1+j] = '0;
            assign nd_q[P-1+j] = '0;
            assign nd_x[P-1+j] = '0;
        end
    end

    // right child holds the later seeds and wins ties
    for (genvar k = 0; k < P - 1; k++) begin : g_node
        logic take_r;
        assign take_r = nd_v[2*k+2] && (!nd_v[2*k+1] || (nd_l[2*k+2] <= nd_l[2*k+1]));
        assign nd_v[k] = nd_v[2*k+1] || nd_v[2*k+2];
        assign nd_l[k] = take_r ? nd_l[2*k+2] : nd_l[2*k+1];
        assign nd_i[k] = take_r ? nd_i[2*k+2] : nd_i[2*k+1];
        assign nd_q[k] = take_r ? nd_q[2*k+2] : nd_q[2*k+1];
        assign nd_x[k] = take_r ? nd_x[2*k+2] : nd_x[2*k+1];
    end

    assign pk_idx = nd_x[0];
    assign pk_i   = nd_i[0];
    assign pk_q   = nd_q[0];
    assign pk_l   = nd_l[0];

endmodule

[design/lnsr_ctrl.sv]
// Search sequencer: phase, cursors and running best, one step per word.
`timescale 1ns / 1ps

module lnsr_ctrl #(
    parameter int NUM_SEEDS = 4,
    parameter int DAC_BITS  = 12
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  lnsr_pkg::action_t             act,
    input  logic [11:0]                   adc,
    input  lnsr_pkg::cfg_t                cfg,
    output logic [SIW-1:0]                rd_addr,
    input  logic [BW-1:0]                 rd_i,
    input  logic [BW-1:0]                 rd_q,
    input  logic [lnsr_pkg::LEVEL_W-1:0]  rd_l,
    input  logic [SIW-1:0]                pk_idx,
    input  logic [BW-1:0]                 pk_i,
    input  logic [BW-1:0]                 pk_q,
    input  logic [lnsr_pkg::LEVEL_W-1:0]  pk_l,
    output lnsr_pkg::seed_wr_t            wr,
    output logic [SIW-1:0]                st_idx,
    output logic [BW-1:0]                 st_i,
    output logic [BW-1:0]                 st_q,
    output logic [lnsr_pkg::LEVEL_W-1:0]  st_l,
    output logic [BW-1:0]                 w0_i,
    output logic [BW-1:0]                 w0_q,
    output logic [lnsr_pkg::LEVEL_W-1:0]  w0_l,
    output lnsr_pkg::result_t             res
);
    localparam int BW  = (DAC_BITS > 13) ? DAC_BITS : 13;
    localparam int CW  = BW + 1;
    localparam int SIW = (NUM_SEEDS > 1) ? $clog2(NUM_SEEDS) : 1;
    localparam logic [CW-1:0] DAC_MAX = CW'((1 << DAC_BITS) - 1);

    import lnsr_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [SIW-1:0]     seed_reg, seed_next;
    logic [CW-1:0]      cur_i_reg, cur_i_next, cur_q_reg, cur_q_next;
    logic [BW-1:0]      rb_i_reg, rb_i_next, rb_q_reg, rb_q_next;
    logic [LEVEL_W-1:0] rb_l_reg, rb_l_next;
    logic [BW-1:0]      left_i_reg, left_i_next, left_q_reg, left_q_next;
    logic [BW-1:0]      sc_i_reg, sc_i_next, sc_q_reg, sc_q_next;

    logic [11:0]        cst, fst, span;
    logic               empty;
    logic [12:0]        lvl_m, adc_w;
    logic [CW-1:0]      ci_c, cq_c, ci_f, cq_f, end_i, end_q, scan_hi_w, scan_lo_w;
    logic [SIW:0]       seed_inc, start_idx;
    logic               do_start, sweeping;
    logic [BW-1:0]      fr_w, code_i, code_q;
    logic [SIW+1:0]     seed_w;

    function automatic logic [BW-1:0] sat_code(input logic [CW-1:0] v);
        return (v > DAC_MAX) ? DAC_MAX[BW-1:0] : v[BW-1:0];
    endfunction

    assign cst       = (cfg.coarse_step == 12'd0) ? 12'd1 : cfg.coarse_step;
    assign fst       = (cfg.fine_step == 12'd0) ? 12'd1 : cfg.fine_step;
    assign span      = {cfg.fine_range, 1'b0};
    assign fr_w      = BW'(cfg.fine_range);
    assign empty     = cfg.scan_low > cfg.scan_high;
    assign lvl_m     = {1'b0, rb_l_reg} + {1'b0, cfg.coarse_margin};
    assign adc_w     = {1'b0, adc};
    assign ci_c      = cur_i_reg + CW'(cst);
    assign cq_c      = cur_q_reg + CW'(cst);
    assign ci_f      = cur_i_reg + CW'(fst);
    assign cq_f      = cur_q_reg + CW'(fst);
    assign end_i     = CW'(left_i_reg) + CW'(span);
    assign end_q     = CW'(left_q_reg) + CW'(span);
    assign scan_hi_w = CW'(cfg.scan_high);
    assign scan_lo_w = CW'(cfg.scan_low);
    assign seed_inc  = {1'b0, seed_reg} + (SIW+1)'(1);

    // one table read: next seed on a sample, seed 0 on a start
    always_comb begin
        if (act == ACT_SAMPLE && seed_inc < (SIW+1)'(NUM_SEEDS)) begin
            rd_addr = seed_inc[SIW-1:0];
        end else begin
            rd_addr = '0;
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        seed_next   = seed_reg;
        cur_i_next  = cur_i_reg;
        cur_q_next  = cur_q_reg;
        rb_i_next   = rb_i_reg;
        rb_q_next   = rb_q_reg;
        rb_l_next   = rb_l_reg;
        left_i_next = left_i_reg;
        left_q_next = left_q_reg;
        sc_i_next   = sc_i_reg;
        sc_q_next   = sc_q_reg;
        wr          = '0;
        st_idx      = seed_reg;
        st_i        = rb_i_reg;
        st_q        = rb_q_reg;
        st_l        = rb_l_reg;
        w0_i        = rb_i_reg;
        w0_q        = rb_q_reg;
        w0_l        = adc;
        do_start    = 1'b0;
        start_idx   = '0;

        if (step) begin
            unique case (act)
                ACT_FAST: begin
                    do_start  = 1'b1;
                    start_idx = '0;
                end
                ACT_FULL: begin
                    seed_next = '0;
                    rb_l_next = LEVEL_MAX;
                    rb_i_next = rd_i;
                    rb_q_next = rd_q;
                    if (empty) begin
                        phase_next = PH_CONFIRM;
                    end else begin
                        cur_i_next = scan_lo_w;
                        cur_q_next = scan_lo_w;
                        phase_next = PH_GRID;
                    end
                end
                ACT_SAMPLE: begin
                    case (phase_reg)
                        PH_QSWEEP: begin
                            // strict compare on the Q sweep
                            if (adc_w < lvl_m) begin
                                rb_l_next = adc;
                                rb_q_next = cur_q_reg[BW-1:0];
                            end
                            if (cq_c > scan_hi_w) begin
                                phase_next = PH_ISWEEP;
                                cur_i_next = scan_lo_w;
                                cur_q_next = CW'(rb_q_next);
                            end else begin
                                cur_q_next = cq_c;
                            end
                        end
                        PH_ISWEEP: begin
                            if (adc_w <= lvl_m) begin
                                rb_l_next = adc;
                                rb_i_next = cur_i_reg[BW-1:0];
                            end
                            cur_i_next = ci_c;
                            if (ci_c > scan_hi_w) begin
                                if (rb_i_next != sc_i_reg) begin
                                    wr.st_en    = 1'b1;
                                    st_i        = rb_i_next;
                                    st_q        = rb_q_next;
                                    st_l        = rb_l_next;
                                    sc_i_next   = rb_i_next;
                                    sc_q_next   = rb_q_next;
                                    left_i_next = (rb_i_next > fr_w) ? rb_i_next - fr_w : '0;
                                    left_q_next = (rb_q_next > fr_w) ? rb_q_next - fr_w : '0;
                                    cur_i_next  = CW'(left_i_next);
                                    cur_q_next  = CW'(left_q_next);
                                    phase_next  = PH_FINE;
                                end else begin
                                    // I did not move: no rewrite, no fine pass
                                    do_start  = 1'b1;
                                    start_idx = seed_inc;
                                end
                            end
                        end
                        PH_FINE: begin
                            if (adc <= rb_l_reg) begin
                                rb_l_next = adc;
                                rb_i_next = sat_code(cur_i_reg);
                                rb_q_next = sat_code(cur_q_reg);
                            end
                            if (cq_f > end_q) begin
                                cur_q_next = CW'(left_q_reg);
                                cur_i_next = ci_f;
                                if (ci_f > end_i) begin
                                    if (rb_i_next != sc_i_reg || rb_q_next != sc_q_reg) begin
                                        wr.st_en = 1'b1;
                                        st_i     = rb_i_next;
                                        st_q     = rb_q_next;
                                        st_l     = rb_l_next;
                                    end
                                    do_start  = 1'b1;
                                    start_idx = seed_inc;
                                end
                            end else begin
                                cur_q_next = cq_f;
                            end
                        end
                        PH_GRID: begin
                            if (adc <= rb_l_reg) begin
                                rb_l_next = adc;
                                rb_i_next = cur_i_reg[BW-1:0];
                                rb_q_next = cur_q_reg[BW-1:0];
                            end
                            if (cq_c > scan_hi_w) begin
                                cur_q_next = scan_lo_w;
                                cur_i_next = ci_c;
                                if (ci_c > scan_hi_w) begin
                                    phase_next = PH_CONFIRM;
                                end
                            end else begin
                                cur_q_next = cq_c;
                            end
                        end
                        PH_CONFIRM: begin
                            wr.w0_en     = 1'b1;
                            wr.w0_lvl_en = 1'b1;
                            w0_i         = rb_i_reg;
                            w0_q         = rb_q_reg;
                            w0_l         = adc;
                            rb_l_next    = adc;
                            phase_next   = PH_DONE;
                        end
                        default: begin
                        end
                    endcase
                end
                ACT_NOP: begin
                end
            endcase

            if (do_start) begin
                if (start_idx >= (SIW+1)'(NUM_SEEDS) || empty) begin
                    // all seeds done or an empty scan range: take the best, later seed on a tie
                    wr.w0_en   = 1'b1;
                    w0_i       = pk_i;
                    w0_q       = pk_q;
                    rb_i_next  = pk_i;
                    rb_q_next  = pk_q;
                    rb_l_next  = pk_l;
                    seed_next  = pk_idx;
                    phase_next = PH_DONE;
                end else begin
                    seed_next  = start_idx[SIW-1:0];
                    rb_i_next  = rd_i;
                    rb_q_next  = rd_q;
                    rb_l_next  = rd_l;
                    sc_i_next  = rd_i;
                    sc_q_next  = rd_q;
                    cur_i_next = CW'(rd_i);
                    cur_q_next = scan_lo_w;
                    phase_next = PH_QSWEEP;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            seed_reg   <= '0;
            cur_i_reg  <= '0;
            cur_q_reg  <= '0;
            rb_i_reg   <= '0;
            rb_q_reg   <= '0;
            rb_l_reg   <= LEVEL_MAX;
            left_i_reg <= '0;
            left_q_reg <= '0;
            sc_i_reg   <= '0;
            sc_q_reg   <= '0;
        end else begin
            phase_reg  <= phase_next;
            seed_reg   <= seed_next;
            cur_i_reg  <= cur_i_next;
            cur_q_reg  <= cur_q_next;
            rb_i_reg   <= rb_i_next;
            rb_q_reg   <= rb_q_next;
            rb_l_reg   <= rb_l_next;
            left_i_reg <= left_i_next;
            left_q_reg <= left_q_next;
            sc_i_reg   <= sc_i_next;
            sc_q_reg   <= sc_q_next;
        end
    end

    // status after this word
    always_comb begin
        case (phase_next) inside
            PH_QSWEEP, PH_ISWEEP, PH_FINE, PH_GRID: sweeping = 1'b1;
            default:                                 sweeping = 1'b0;
        endcase
    end

    assign code_i = sweeping ? sat_code(cur_i_next) : sat_code(CW'(rb_i_next));
    assign code_q = sweeping ? sat_code(cur_q_next) : sat_code(CW'(rb_q_next));
    assign seed_w = {2'b00, seed_next};

    always_comb begin
        res.dac_i         = code_i[OUT_CODE_W-1:0];
        res.dac_q         = code_q[OUT_CODE_W-1:0];
        res.sample_wanted = sweeping || (phase_next == PH_CONFIRM);
        res.done_res      = (phase_next == PH_DONE);
        res.best_level    = rb_l_next;
        res.best_seed     = seed_w[1:0];
    end

endmodule

[design/iq_leakage_null_search.sv]
// Top level of the I/Q leakage null search: stream ports, registers, word staging.
`timescale 1ns / 1ps

// I/Q leakage null search. Each input word carries a kind on s_tuser (start fast
// seeded search, start full grid search, ADC sample, no operation) and the ADC
// level on s_tdata. Every word but a no-operation gives one result word with the
// next I/Q DAC codes, a sample-wanted flag, a done flag, the lowest level so far
// and the seed index. Drive the DAC with the codes, wait out the analogue
// settling, then send the measured level as a sample word. Fast mode runs a
// coarse Q sweep then a coarse I sweep per seed, plus a fine 2-D grid when I
// moved, and ends on the best seed (later seed wins a tie). Full mode scans a
// coarse 2-D grid and takes one confirming sample. Start words restart at any
// time; a sample nobody asked for just repeats the status. Timing: one word
// accepted per clock while the sink keeps up; a word is held in the input
// register, then the sequencer step and seed selection go into the result
// register. m_tready low stalls the input side only once both registers are
// full. No clearing pass after reset. Registers are written via cfg_we/cfg_addr/
// cfg_wdata; the user must do so only while no word is in flight (not enforced).
module iq_leakage_null_search #(
    parameter int NUM_SEEDS = 4,
    parameter int DAC_BITS  = 12
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lnsr_pkg::S_TDATA_W-1:0]    s_tdata,  // adc_value[11:0], zero pad
    input  logic [lnsr_pkg::S_TUSER_W-1:0]    s_tuser,  // action[1:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lnsr_pkg::M_TDATA_W-1:0]    m_tdata,  // dac_i[11:0], dac_q[23:12],
                                                        // sample_wanted[24], done_res[25],
                                                        // best_level[37:26], best_seed[39:38]
    input  logic                              cfg_we,
    input  logic [lnsr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [lnsr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    localparam int BW  = (DAC_BITS > 13) ? DAC_BITS : 13;
    localparam int SIW = (NUM_SEEDS > 1) ? $clog2(NUM_SEEDS) : 1;

    import lnsr_pkg::*;

    // input word register
    logic         in_vld_reg;
    action_t      in_act_reg;
    logic [11:0]  in_adc_reg;

    // result register
    logic         out_vld_reg;
    result_t      out_data_reg;

    cfg_t         cfg_reg;

    logic         advance;
    result_t      res;

    seed_wr_t           wr;
    logic [SIW-1:0]     st_idx, rd_addr, pk_idx;
    logic [BW-1:0]      st_i, st_q, w0_i, w0_q, rd_i, rd_q, pk_i, pk_q;
    logic [LEVEL_W-1:0] st_l, w0_l, rd_l, pk_l;

    // word moves on when the result slot is free or being emptied
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_act_reg <= action_t'(s_tuser);
            in_adc_reg <= s_tdata[11:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance && in_act_reg != ACT_NOP) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_act_reg != ACT_NOP) begin
            out_data_reg <= res;
        end
    end

    // register file, write only
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scan_low      <= SCAN_LOW_RST;
            cfg_reg.scan_high     <= SCAN_HIGH_RST;
            cfg_reg.coarse_step   <= COARSE_STEP_RST;
            cfg_reg.fine_step     <= FINE_STEP_RST;
            cfg_reg.fine_range    <= FINE_RANGE_RST;
            cfg_reg.coarse_margin <= COARSE_MARGIN_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_SCAN_LOW:      cfg_reg.scan_low      <= cfg_wdata;
                CFG_SCAN_HIGH:     cfg_reg.scan_high     <= cfg_wdata;
                CFG_COARSE_STEP:   cfg_reg.coarse_step   <= cfg_wdata;
                CFG_FINE_STEP:     cfg_reg.fine_step     <= cfg_wdata;
                CFG_FINE_RANGE:    cfg_reg.fine_range    <= cfg_wdata[10:0];
                CFG_COARSE_MARGIN: cfg_reg.coarse_margin <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    lnsr_ctrl #(
        .NUM_SEEDS (NUM_SEEDS),
        .DAC_BITS  (DAC_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .act     (in_act_reg),
        .adc     (in_adc_reg),
        .cfg     (cfg_reg),
        .rd_addr (rd_addr),
        .rd_i    (rd_i),
        .rd_q    (rd_q),
        .rd_l    (rd_l),
        .pk_idx  (pk_idx),
        .pk_i    (pk_i),
        .pk_q    (pk_q),
        .pk_l    (pk_l),
        .wr      (wr),
        .st_idx  (st_idx),
        .st_i    (st_i),
        .st_q    (st_q),
        .st_l    (st_l),
        .w0_i    (w0_i),
        .w0_q    (w0_q),
        .w0_l    (w0_l),
        .res     (res)
    );

    lnsr_seed_tab #(
        .NUM_SEEDS (NUM_SEEDS),
        .DAC_BITS  (DAC_BITS)
    ) u_seed_tab (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .st_idx  (st_idx),
        .st_i    (st_i),
        .st_q    (st_q),
        .st_l    (st_l),
        .w0_i    (w0_i),
        .w0_q    (w0_q),
        .w0_l    (w0_l),
        .rd_addr (rd_addr),
        .rd_i    (rd_i),
        .rd_q    (rd_q),
        .rd_l    (rd_l),
        .pk_idx  (pk_idx),
        .pk_i    (pk_i),
        .pk_q    (pk_q),
        .pk_l    (pk_l)
    );

    // input side only stalls with both registers full and the sink stalled
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_vld_reg && out_vld_reg && !m_tready))
        else $error("input stalled without a full, stalled result register");

    // a no-operation word leaves no result behind
    a_nop_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_act_reg == ACT_NOP) |=> !out_vld_reg)
        else $error("no-operation word produced a result");

    // a finished search never asks for a sample
    a_done_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg |-> !(out_data_reg.done_res && out_data_reg.sample_wanted))
        else $error("result both done and waiting for a sample");

endmodule
